// ----- hdl/mesh_face_identify_assert.svh -----
// Assertion macros for the mesh face identification block.
// Included by the top level; define NO_ASSERTIONS to compile the checks away.
`ifndef MESH_FACE_IDENTIFY_ASSERT_SVH
`define MESH_FACE_IDENTIFY_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define MFI_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mesh_face_identify: same-cycle check failed");
// Next-cycle implication, disabled while reset is high.
`define MFI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mesh_face_identify: next-cycle check failed");
`else
`define MFI_ASSERT(name, clk, rst, prop)
`define MFI_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/mfi_pkg.sv -----
// Shared types and constants for the mesh face identification block.
// No dependencies; the interfaces and modules of the block refer to it by scoped names.
package mfi_pkg;

   localparam int FACE_W   = 12;
   localparam int VERTEX_W = 10;
   localparam int STATUS_W = 2;

   localparam int NUM_VERTICES_DEF = 1024;
   localparam int MAX_FACES_DEF    = 8;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_APPENDED  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_STREAM,
      ST_FIN,
      ST_EMIT
   } state_type;

   // Control bundle broadcast from the sequencer to every candidate cell.
   typedef struct packed {
      logic start;   // clear match counters, link valids and the running total
      logic seed;    // the current query vertex seeds the candidate list
      logic shift;   // seed mode: shift candidates one cell down the row
      logic fin;     // intersect mode: fold match counts into the weights
   } ctl_type;

endpackage

// ----- hdl/mfi_chan_if.sv -----
// Handshake channels of the mesh face identification block.
// Depends on mfi_pkg for the payload widths.
interface mfi_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [mfi_pkg::VERTEX_W-1:0]  vertex;
   logic [mfi_pkg::FACE_W-1:0]    face_in;
   logic                          last_vertex;

   modport source (output valid, command, vertex, face_in, last_vertex, input ready);
   modport sink   (input valid, command, vertex, face_in, last_vertex, output ready);
endinterface

interface mfi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mfi_pkg::FACE_W-1:0]    face_out;
   logic [mfi_pkg::STATUS_W-1:0]  status;

   modport source (output valid, face_out, status, input ready);
   modport sink   (input valid, face_out, status, output ready);
endinterface

// ----- hdl/mfi_cell.sv -----
// One candidate cell: holds a candidate face with its weight and match count.
// Depends on mfi_pkg; instantiated in a row by mfi_chain.
module mfi_cell #(
   parameter int  MAX_FACES = mfi_pkg::MAX_FACES_DEF,
   localparam int WW        = $clog2(MAX_FACES + 2)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mfi_pkg::ctl_type            ctl,
   input  logic [mfi_pkg::FACE_W-1:0]  in_val,
   input  logic                        in_vld,
   input  logic [WW-1:0]               in_acc,
   output logic [mfi_pkg::FACE_W-1:0]  out_val,
   output logic                        out_vld,
   output logic [WW-1:0]               out_acc
);

   localparam int            MW    = $clog2(MAX_FACES + 1);
   localparam logic [WW:0]   W_SAT = (WW + 1)'(MAX_FACES + 1);

   logic [mfi_pkg::FACE_W-1:0] cand_ff, cand_in;
   logic [WW-1:0]              w_ff, w_in;
   logic [MW-1:0]              m_ff, m_in;
   logic [mfi_pkg::FACE_W-1:0] lval_ff, lval_in;
   logic                       lvld_ff, lvld_in;
   logic [WW-1:0]              lacc_ff, lacc_in;
   logic                       match;
   logic [WW:0]                acc_sum;
   logic [WW+MW-1:0]           prod;

   always_comb begin
      // A cell with zero weight stands for no copies and never matches.
      match   = in_vld && (w_ff != '0) && (in_val == cand_ff);
      acc_sum = {1'b0, in_acc} + (match ? {1'b0, w_ff} : '0);
      prod    = (WW + MW)'(w_ff) * (WW + MW)'(m_ff);

      cand_in = cand_ff;
      w_in    = w_ff;
      if (ctl.shift) begin
         cand_in = in_val;
         w_in    = in_vld ? WW'(1) : '0;
      end else if (ctl.fin && !ctl.seed) begin
         w_in = (prod > (WW + MW)'(MAX_FACES + 1)) ? W_SAT[WW-1:0] : prod[WW-1:0];
      end

      m_in = m_ff;
      if (ctl.start) begin
         m_in = '0;
      end else if (!ctl.seed && match) begin
         m_in = m_ff + MW'(1);
      end

      lvld_in = !ctl.start && !ctl.seed && in_vld;
      lval_in = in_val;
      lacc_in = (acc_sum > W_SAT) ? W_SAT[WW-1:0] : acc_sum[WW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= '0;
         m_ff    <= '0;
         lvld_ff <= 1'b0;
      end else begin
         w_ff    <= w_in;
         m_ff    <= m_in;
         lvld_ff <= lvld_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      lval_ff <= lval_in;
      lacc_ff <= lacc_in;
   end

   // Seed mode turns the row into a shift line of candidates; otherwise the
   // link registers carry list entries and their running weight sums.
   assign out_val = ctl.seed ? cand_ff : lval_ff;
   assign out_vld = ctl.seed ? (w_ff != '0) : lvld_ff;
   assign out_acc = ctl.seed ? '0 : lacc_ff;

endmodule

// ----- hdl/mfi_chain.sv -----
// Row of candidate cells plus the tail accumulator of kept copies.
// Depends on mfi_pkg and mfi_cell.
module mfi_chain #(
   parameter int  MAX_FACES = mfi_pkg::MAX_FACES_DEF,
   localparam int WW        = $clog2(MAX_FACES + 2)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mfi_pkg::ctl_type            ctl,
   input  logic [mfi_pkg::FACE_W-1:0]  head_val,
   input  logic                        head_vld,
   output logic [WW-1:0]               total,
   output logic [mfi_pkg::FACE_W-1:0]  face
);

   localparam logic [WW:0] W_SAT = (WW + 1)'(MAX_FACES + 1);

   logic [mfi_pkg::FACE_W-1:0] val_w [MAX_FACES+1];
   logic                       vld_w [MAX_FACES+1];
   logic [WW-1:0]              acc_w [MAX_FACES+1];

   logic [WW-1:0]              total_ff, total_in;
   logic [mfi_pkg::FACE_W-1:0] face_ff, face_in;
   logic [WW:0]                sum;

   assign val_w[0] = head_val;
   assign vld_w[0] = head_vld;
   assign acc_w[0] = '0;

   for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
      mfi_cell #(.MAX_FACES(MAX_FACES)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .in_val  (val_w[i]),
         .in_vld  (vld_w[i]),
         .in_acc  (acc_w[i]),
         .out_val (val_w[i+1]),
         .out_vld (vld_w[i+1]),
         .out_acc (acc_w[i+1])
      );
   end

   always_comb begin
      total_in = total_ff;
      face_in  = face_ff;
      sum      = '0;
      if (ctl.start) begin
         total_in = '0;
      end else if (ctl.seed) begin
         // Every list entry shifted in becomes one candidate copy.
         if (ctl.shift && head_vld) begin
            sum      = {1'b0, total_ff} + (WW + 1)'(1);
            total_in = (sum > W_SAT) ? W_SAT[WW-1:0] : sum[WW-1:0];
            face_in  = head_val;
         end
      end else if (vld_w[MAX_FACES] && (acc_w[MAX_FACES] != '0)) begin
         sum      = {1'b0, total_ff} + {1'b0, acc_w[MAX_FACES]};
         total_in = (sum > W_SAT) ? W_SAT[WW-1:0] : sum[WW-1:0];
         face_in  = val_w[MAX_FACES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      face_ff <= face_in;
   end

   assign total = total_ff;
   assign face  = face_ff;

endmodule

// ----- hdl/mesh_face_identify.sv -----
// Mesh face identification: vertex-to-face adjacency table with a face query.
// Items arrive on req_ch (command, vertex, face_in, last_vertex) and results
// leave on rsp_ch (face_out, status); a transfer happens when valid and ready
// are both high at a rising clock edge.
// An append transfer returns one result (appended or list full); it passes
// the count step and the final step, which loads the output register, and the
// block takes no new item meanwhile. A query is a run of query transfers; only
// the one marked last_vertex returns a result (found with the face, or not found).
// Each query vertex passes the count step, the stream step and the fin step,
// and the marked vertex then loads its result in the final step: the list
// entries are read one per cycle from the face memory and then travel through
// the row of MAX_FACES_PER_VERTEX candidate cells, one cell per cycle.
// After reset the list count memory is swept to zero, one vertex per cycle,
// so req_ch.ready stays low until the sweep has covered every vertex.
// Results wait in an output register; while the receiver stalls, the block
// holds the next result in its final step and stops taking new items.
// Depends on mfi_pkg, mfi_chan_if, mfi_chain and mesh_face_identify_assert.svh.
`include "mesh_face_identify_assert.svh"

module mesh_face_identify #(
   parameter int NUM_VERTICES         = mfi_pkg::NUM_VERTICES_DEF,
   parameter int MAX_FACES_PER_VERTEX = mfi_pkg::MAX_FACES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   mfi_req_if.sink       req_ch,
   mfi_rsp_if.source     rsp_ch
);

   // Widths that follow from the table dimensions.
   localparam int VA     = $clog2(NUM_VERTICES);             // vertex address
   localparam int KW     = $clog2(MAX_FACES_PER_VERTEX);     // slot within a list
   localparam int MW     = $clog2(MAX_FACES_PER_VERTEX + 1); // list length
   localparam int WW     = $clog2(MAX_FACES_PER_VERTEX + 2); // saturating copy count
   localparam int TW     = $clog2(2 * MAX_FACES_PER_VERTEX + 1);
   localparam int FDEPTH = NUM_VERTICES * (2 ** KW);

   localparam logic [VA-1:0] LAST_V    = VA'(NUM_VERTICES - 1);
   localparam logic [TW-1:0] SEED_END  = TW'(MAX_FACES_PER_VERTEX);
   localparam logic [TW-1:0] INTER_END = TW'(2 * MAX_FACES_PER_VERTEX);

   // Face lists live at {vertex, slot}; list lengths in a separate memory.
   logic [mfi_pkg::FACE_W-1:0] face_mem [FDEPTH];
   logic [MW-1:0]              cnt_mem  [NUM_VERTICES];

   mfi_pkg::state_type state_ff, state_in;
   logic [VA-1:0]              clr_ff, clr_in;
   logic                       cmd_ff, cmd_in;
   logic [VA-1:0]              vaddr_ff, vaddr_in;
   logic                       inrange_ff, inrange_in;
   logic [mfi_pkg::FACE_W-1:0] face_in_ff, face_in_in;
   logic                       last_ff, last_in;
   logic [MW-1:0]              n_ff, n_in;
   logic [TW-1:0]              t_ff, t_in;
   logic                       seed_ff, seed_in;
   logic                       qact_ff, qact_in;
   logic                       ovf_ff, ovf_in;
   logic [mfi_pkg::FACE_W-1:0] pend_face_ff, pend_face_in;
   logic [mfi_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [mfi_pkg::FACE_W-1:0] rsp_face_ff, rsp_face_in;
   logic [mfi_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                       feed_vld_ff;
   logic                       feed_act_ff;
   logic [mfi_pkg::FACE_W-1:0] face_rd_ff;
   logic [MW-1:0]              cnt_rd_ff;

   logic                       req_ready;
   logic                       cnt_we;
   logic [VA-1:0]              cnt_wa;
   logic [MW-1:0]              cnt_wd;
   logic                       face_we;
   logic [MW-1:0]              n_now;
   logic                       ovf_now;
   logic                       found;
   mfi_pkg::ctl_type           ctl;
   logic [WW-1:0]              chain_total;
   logic [mfi_pkg::FACE_W-1:0] chain_face;

   mfi_chain #(.MAX_FACES(MAX_FACES_PER_VERTEX)) u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .head_val (face_rd_ff),
      .head_vld (feed_vld_ff),
      .total    (chain_total),
      .face     (chain_face)
   );

   // Sequencer: next state, memory write strobes and cell controls.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      cmd_in         = cmd_ff;
      vaddr_in       = vaddr_ff;
      inrange_in     = inrange_ff;
      face_in_in     = face_in_ff;
      last_in        = last_ff;
      n_in           = n_ff;
      t_in           = t_ff;
      seed_in        = seed_ff;
      qact_in        = qact_ff;
      ovf_in         = ovf_ff;
      pend_face_in   = pend_face_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_face_in    = rsp_face_ff;
      rsp_status_in  = rsp_status_ff;
      req_ready      = 1'b0;
      cnt_we         = 1'b0;
      cnt_wa         = clr_ff;
      cnt_wd         = '0;
      face_we        = 1'b0;
      ctl            = '{start: 1'b0, seed: seed_ff, shift: 1'b0, fin: 1'b0};
      // An out-of-range vertex has an empty list.
      n_now          = inrange_ff ? cnt_rd_ff : '0;
      ovf_now        = seed_ff ? 1'b0
                     : (ovf_ff || (chain_total > WW'(MAX_FACES_PER_VERTEX)));
      found          = !ovf_now && (chain_total == WW'(1));

      case (state_ff)
         mfi_pkg::ST_CLEAR: begin
            cnt_we = 1'b1;
            clr_in = clr_ff + VA'(1);
            if (clr_ff == LAST_V) begin
               state_in = mfi_pkg::ST_IDLE;
            end
         end
         mfi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               cmd_in     = req_ch.command;
               vaddr_in   = VA'(req_ch.vertex);
               inrange_in = (32'(req_ch.vertex) < 32'(NUM_VERTICES));
               face_in_in = req_ch.face_in;
               last_in    = req_ch.last_vertex;
               state_in   = mfi_pkg::ST_COUNT;
            end
         end
         mfi_pkg::ST_COUNT: begin
            if (cmd_ff == mfi_pkg::CMD_QUERY) begin
               // The first vertex of a query seeds, the rest intersect.
               n_in      = n_now;
               seed_in   = !qact_ff;
               t_in      = '0;
               ctl.start = 1'b1;
               state_in  = mfi_pkg::ST_STREAM;
            end else begin
               pend_face_in = '0;
               if (!inrange_ff || (n_now >= MW'(MAX_FACES_PER_VERTEX))) begin
                  pend_status_in = mfi_pkg::STAT_FULL;
               end else begin
                  face_we        = 1'b1;
                  cnt_we         = 1'b1;
                  cnt_wa         = vaddr_ff;
                  cnt_wd         = n_now + MW'(1);
                  pend_status_in = mfi_pkg::STAT_APPENDED;
               end
               state_in = mfi_pkg::ST_EMIT;
            end
         end
         mfi_pkg::ST_STREAM: begin
            t_in      = t_ff + TW'(1);
            ctl.shift = seed_ff && feed_act_ff;
            if (t_ff == (seed_ff ? SEED_END : INTER_END)) begin
               state_in = mfi_pkg::ST_FIN;
            end
         end
         mfi_pkg::ST_FIN: begin
            ctl.fin = 1'b1;
            ovf_in  = ovf_now;
            qact_in = !last_ff;
            if (last_ff) begin
               pend_status_in = found ? mfi_pkg::STAT_FOUND : mfi_pkg::STAT_NOT_FOUND;
               pend_face_in   = found ? chain_face : '0;
               state_in       = mfi_pkg::ST_EMIT;
            end else begin
               state_in = mfi_pkg::ST_IDLE;
            end
         end
         mfi_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_face_in   = pend_face_ff;
               rsp_status_in = pend_status_ff;
               state_in      = mfi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfi_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfi_pkg::ST_CLEAR;
         clr_ff       <= '0;
         qact_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         seed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         feed_vld_ff  <= 1'b0;
         feed_act_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         qact_ff      <= qact_in;
         ovf_ff       <= ovf_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
         // Read data of list slot t_ff reaches the head of the row in the next cycle.
         feed_vld_ff  <= (state_ff == mfi_pkg::ST_STREAM) && (t_ff < TW'(n_ff));
         feed_act_ff  <= (state_ff == mfi_pkg::ST_STREAM) && (t_ff < SEED_END);
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      vaddr_ff       <= vaddr_in;
      inrange_ff     <= inrange_in;
      face_in_ff     <= face_in_in;
      last_ff        <= last_in;
      n_ff           <= n_in;
      t_ff           <= t_in;
      pend_face_ff   <= pend_face_in;
      pend_status_ff <= pend_status_in;
      rsp_face_ff    <= rsp_face_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // List count memory: one write port (clear sweep or append), one read port
   // addressed by the incoming vertex so the count is ready the next cycle.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= cnt_mem[VA'(req_ch.vertex)];
   end

   // Face list memory: append writes the next free slot, a query reads one
   // slot per cycle.
   always_ff @(posedge clock) begin
      if (face_we) begin
         face_mem[{vaddr_ff, n_now[KW-1:0]}] <= face_in_ff;
      end
      face_rd_ff <= face_mem[{vaddr_ff, t_ff[KW-1:0]}];
   end

   assign req_ch.ready    = req_ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.face_out = rsp_face_ff;
   assign rsp_ch.status   = rsp_status_ff;

   // An entry only enters the cell row in the cycle after a streaming step.
   `MFI_ASSERT(a_feed_in_stream, clock, reset, feed_vld_ff |-> ($past(state_ff) == mfi_pkg::ST_STREAM))
   // After seeding, the running copy count equals the seeding vertex's list length.
   `MFI_ASSERT(a_seed_total, clock, reset, (state_ff == mfi_pkg::ST_FIN && seed_ff) |-> (chain_total == WW'(n_ff)))
   // A result leaving the final step is presented on the next cycle.
   `MFI_ASSERT_NEXT(a_emit_loads, clock, reset, (state_ff == mfi_pkg::ST_EMIT && (!rsp_valid_ff || rsp_ch.ready)), (rsp_valid_ff && state_ff == mfi_pkg::ST_IDLE))

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for mesh_face_identify: builds vertex-to-face lists,
// runs face queries and checks every result against a bench model or a directed row.
// Depends on mfi_pkg, the mfi_req_if / mfi_rsp_if interfaces and the block RTL.
`timescale 1ns / 100ps

module tb_top;
   import mfi_pkg::*;

   localparam int NV = NUM_VERTICES_DEF;
   localparam int MF = MAX_FACES_DEF;

   // Random items that follow the directed rows; together about 1850 items.
   localparam int RANDOM_ITEMS = 1824;

   // The block sweeps its count memory after reset, and the receiver makes one
   // long hold of ready in the pressure phase; the watchdog limit exceeds both.
   localparam int HOLD_CYCLES    = 2000;
   localparam int WATCHDOG_LIMIT = 20000;

   // Cycles left after the last result so that a stray result still shows up.
   localparam int SETTLE_CYCLES  = 64;

   typedef struct packed {
      bit                command;
      bit [VERTEX_W-1:0] vertex;
      bit [FACE_W-1:0]   face_in;
      bit                last_vertex;
   } mesh_item_type;

   typedef struct packed {
      bit [FACE_W-1:0]   face_out;
      bit [STATUS_W-1:0] status;
   } mesh_result_type;

   // One row of the directed part. When typed is set, the row carries the
   // result that the block must return; otherwise the face model decides.
   typedef struct packed {
      mesh_item_type   item;
      bit              typed;
      mesh_result_type result;
   } stim_row_type;

   // A face placed on a few vertices, kept so that later queries can ask for it.
   typedef struct {
      bit [FACE_W-1:0]   face;
      bit [VERTEX_W-1:0] verts [4];
      int unsigned       n;
   } placed_face_type;

   typedef enum int {
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH,
      PH_PRESSURE
   } traffic_phase_type;

   localparam int DIRECTED_ROWS = 26;

   // The overflow case: vertex 40 holds 6,5,5 and vertex 41 holds 5,5,5,5,6, so
   // the second step of the query finds nine matches and drops one. Vertex 42
   // then narrows the list to the single face 6, but the query must still end
   // not found because the running list overflowed on the way.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // A query right after reset sees only empty lists.
      '{'{CMD_QUERY,  10'd5,    12'd0,    1'b1}, 1'b1, '{12'd0,    STAT_NOT_FOUND}},
      // Single-vertex queries with the extreme face and vertex numbers.
      '{'{CMD_APPEND, 10'd3,    12'd4095, 1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_QUERY,  10'd3,    12'd0,    1'b1}, 1'b1, '{12'd4095, STAT_FOUND}},
      '{'{CMD_APPEND, 10'd1023, 12'd0,    1'b1}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_QUERY,  10'd1023, 12'd4095, 1'b1}, 1'b1, '{12'd0,    STAT_FOUND}},
      '{'{CMD_APPEND, 10'd40,   12'd6,    1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd40,   12'd5,    1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd40,   12'd5,    1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd41,   12'd5,    1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd41,   12'd5,    1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd41,   12'd5,    1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd41,   12'd5,    1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd41,   12'd6,    1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd42,   12'd6,    1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_QUERY,  10'd40,   12'd0,    1'b0}, 1'b0, '{12'd0,    STAT_FOUND}},
      '{'{CMD_QUERY,  10'd41,   12'd0,    1'b0}, 1'b0, '{12'd0,    STAT_FOUND}},
      '{'{CMD_QUERY,  10'd42,   12'd0,    1'b1}, 1'b1, '{12'd0,    STAT_NOT_FOUND}},
      // Fill vertex 41 to eight entries, then one more append must bounce.
      '{'{CMD_APPEND, 10'd41,   12'd2730, 1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd41,   12'd1365, 1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd41,   12'd2048, 1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_APPEND, 10'd41,   12'd1,    1'b0}, 1'b1, '{12'd0,    STAT_FULL}},
      // An empty first list keeps the running list empty to the end.
      '{'{CMD_QUERY,  10'd5,    12'd0,    1'b0}, 1'b0, '{12'd0,    STAT_FOUND}},
      '{'{CMD_QUERY,  10'd3,    12'd0,    1'b1}, 1'b1, '{12'd0,    STAT_NOT_FOUND}},
      // An append in the middle of a query is seen by the later vertices.
      '{'{CMD_QUERY,  10'd3,    12'd0,    1'b0}, 1'b0, '{12'd0,    STAT_FOUND}},
      '{'{CMD_APPEND, 10'd1023, 12'd4095, 1'b0}, 1'b1, '{12'd0,    STAT_APPENDED}},
      '{'{CMD_QUERY,  10'd1023, 12'd0,    1'b1}, 1'b0, '{12'd0,    STAT_FOUND}}
   };

   logic clock;
   logic reset;

   mfi_req_if req_ch ();
   mfi_rsp_if rsp_ch ();

   mesh_face_identify i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Adjacency model: face lists, their fill counts and the running candidates
   // of the query in progress. Module-level bit arrays start at zero, which is
   // the state the block reaches after its clearing sweep.
   bit [FACE_W-1:0] adj_faces [NV][MF];
   int unsigned     adj_count [NV];
   bit [FACE_W-1:0] run_cands [MF];
   int unsigned     run_count;
   bit              run_overflow;
   bit              run_open;

   mesh_result_type   pending_results [$];
   mesh_item_type     random_items [$];
   traffic_phase_type traffic = PH_FREE;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                mismatches = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one accepted item to the adjacency model. Returns 1 when the item
   // produces a result, which is then placed in res.
   function automatic bit step_adjacency(input mesh_item_type it,
                                         output mesh_result_type res);
      bit [FACE_W-1:0] kept [MF];
      int unsigned     n;
      int unsigned     kc;
      res = '0;
      // Vertex indexes are ten bits wide and the table has 1024 lists, so
      // every vertex that can be sent is in range.
      n = adj_count[it.vertex];
      if (it.command == CMD_APPEND) begin
         if (n >= MF) begin
            res.status = STAT_FULL;
         end else begin
            adj_faces[it.vertex][n] = it.face_in;
            adj_count[it.vertex] = n + 1;
            res.status = STAT_APPENDED;
         end
         return 1'b1;
      end
      if (!run_open) begin
         // First vertex of a query: its list seeds the candidates.
         for (int unsigned k = 0; k < n; k++) run_cands[k] = adj_faces[it.vertex][k];
         run_count = n;
         run_overflow = 1'b0;
      end else begin
         // Every candidate survives once per equal entry, so duplicates multiply.
         kc = 0;
         for (int unsigned a = 0; a < run_count; a++) begin
            for (int unsigned b = 0; b < n; b++) begin
               if (run_cands[a] == adj_faces[it.vertex][b]) begin
                  if (kc < MF) begin
                     kept[kc] = run_cands[a];
                     kc++;
                  end else begin
                     run_overflow = 1'b1;
                  end
               end
            end
         end
         for (int unsigned k = 0; k < kc; k++) run_cands[k] = kept[k];
         run_count = kc;
      end
      if (!it.last_vertex) begin
         run_open = 1'b1;
         return 1'b0;
      end
      run_open = 1'b0;
      if (!run_overflow && run_count == 1) begin
         res.face_out = run_cands[0];
         res.status = STAT_FOUND;
      end else begin
         res.status = STAT_NOT_FOUND;
      end
      return 1'b1;
   endfunction

   // Plans the random traffic. Most of it places faces on a few neighboring
   // vertices and then queries those vertices again, so that queries walk
   // through real intersections. Placement favors the first 63 vertices so
   // their lists fill up, and half of the faces come from a small set so that
   // lists share faces and candidates multiply. The rest is noise: lone items
   // with every field random, including queries left open with no last vertex.
   task automatic plan_random_items(input int unsigned target);
      placed_face_type   rec;
      placed_face_type   placed [$];
      bit [VERTEX_W-1:0] order [6];
      bit [VERTEX_W-1:0] swap_v;
      mesh_item_type     it;
      int unsigned       kind;
      int unsigned       base;
      int unsigned       n;
      int unsigned       j;
      int unsigned       insert_at;
      while (random_items.size() < target) begin
         kind = $urandom_range(99);
         if (kind < 35 || placed.size() == 0) begin
            rec.face = $urandom_range(1) ? FACE_W'($urandom) : FACE_W'($urandom_range(15));
            base = ($urandom_range(9) < 7) ? $urandom_range(47) : $urandom_range(NV - 16);
            rec.n = $urandom_range(3, 4);
            for (int unsigned k = 0; k < rec.n; k++) begin
               rec.verts[k] = VERTEX_W'(base + $urandom_range(15));
               it = '{CMD_APPEND, rec.verts[k], rec.face, 1'($urandom)};
               random_items = {random_items, it};
            end
            placed = {placed, rec};
            if (placed.size() > 64) void'(placed.pop_front());
         end else if (kind < 85) begin
            rec = placed[$urandom_range(placed.size() - 1)];
            n = rec.n;
            for (int unsigned k = 0; k < n; k++) order[k] = rec.verts[k];
            for (int unsigned k = n - 1; k > 0; k--) begin
               j = $urandom_range(k);
               swap_v = order[k];
               order[k] = order[j];
               order[j] = swap_v;
            end
            // Sometimes ask with only two of the vertices, sometimes revisit one.
            if ($urandom_range(3) == 0) n = 2;
            if ($urandom_range(9) == 0) begin
               order[n] = order[0];
               n++;
            end
            // Some queries get an append slipped in between their vertices.
            insert_at = (kind >= 75) ? $urandom_range(n - 1, 1) : n;
            for (int unsigned k = 0; k < n; k++) begin
               if (k == insert_at) begin
                  it = '{CMD_APPEND, order[$urandom_range(n - 1)],
                         $urandom_range(1) ? rec.face : FACE_W'($urandom), 1'($urandom)};
                  random_items = {random_items, it};
               end
               it = '{CMD_QUERY, order[k], FACE_W'($urandom), k == n - 1};
               random_items = {random_items, it};
            end
         end else begin
            it = '{1'($urandom), VERTEX_W'($urandom), FACE_W'($urandom), 1'($urandom)};
            random_items = {random_items, it};
         end
      end
   endtask

   // Offers one item on the request channel and waits for its transfer. The
   // task starts and ends on a falling edge; valid stays high between items
   // unless an idle cycle is drawn, so it is never lowered and raised at once.
   task automatic send_item(input mesh_item_type it, input bit typed,
                            input mesh_result_type typed_res);
      mesh_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= it.command;
      req_ch.vertex      <= it.vertex;
      req_ch.face_in     <= it.face_in;
      req_ch.last_vertex <= it.last_vertex;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      // The transfer happened at this edge; its result, if any, comes later.
      if (step_adjacency(it, predicted)) begin
         pending_results = {pending_results, typed ? typed_res : predicted};
      end
      @(negedge clock);
   endtask

   // Drops valid and waits until every expected result has been received.
   // At least one edge passes, so valid is never set twice in one step.
   task automatic wait_for_results;
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   // Stimulus: reset, the directed rows, then the random items in five traffic
   // phases. Between phases the sender pauses until all results are in.
   initial begin : stimulus
      int per_phase;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.command     = CMD_APPEND;
      req_ch.vertex      = '0;
      req_ch.face_in     = '0;
      req_ch.last_vertex = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].result);
      end

      plan_random_items(RANDOM_ITEMS);
      per_phase = (random_items.size() + 4) / 5;
      for (int i = 0; i < random_items.size(); i++) begin
         if (i % per_phase == 0) begin
            wait_for_results();
            traffic = traffic_phase_type'(i / per_phase);
            case (traffic)
               PH_SEND_IDLE: begin
                  send_idle_pct = 83;
                  recv_stall_pct = 0;
               end
               PH_RECV_STALL: begin
                  send_idle_pct = 0;
                  recv_stall_pct = 83;
               end
               PH_BOTH: begin
                  send_idle_pct = 14;
                  recv_stall_pct = 14;
               end
               default: begin
                  send_idle_pct = 0;
                  recv_stall_pct = 0;
               end
            endcase
         end
         send_item(random_items[i], 1'b0, '0);
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Result receiver. It stalls at the rate of the current phase, and when the
   // pressure phase begins it holds ready low for one long stretch while
   // the sender keeps offering items, so the block backs up into its input.
   initial begin : result_sink
      int  hold_left;
      bit  held_long;
      hold_left = 0;
      held_long = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (traffic == PH_PRESSURE && !held_long) begin
            held_long = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Result checker: every result transfer is compared field by field with
   // the oldest expected result.
   initial begin : result_check
      mesh_result_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with none expected: face_out %0d status %0d",
                        $time, rsp_ch.face_out, rsp_ch.status);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_ch.status);
                  mismatches++;
               end
               if (rsp_ch.face_out !== want.face_out) begin
                  $display("%0t: face_out expected %0d, got %0d",
                           $time, want.face_out, rsp_ch.face_out);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog: ends the run once the count of cycles in a row with no transfer
   // on either channel reaches WATCHDOG_LIMIT.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mfi_pkg.sv
hdl/mfi_chan_if.sv
hdl/mfi_cell.sv
hdl/mfi_chain.sv
hdl/mesh_face_identify.sv
test/tb_top.sv
